// ----- rtl/m2m4_pkg.sv -----
`default_nettype none
package m2m4_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int AVG_W = 48;
   localparam int ROOT_STEPS = 32;
   localparam int LOG_STEPS = 16;
   localparam logic [25:0] DB_PER_LOG2 = 26'd50504453;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_i;
      logic signed [SAMPLE_BITS-1:0] sample_q;
   } req_type;

   typedef struct packed {
      logic [31:0]        signal_power;
      logic [31:0]        noise_power;
      logic signed [15:0] snr_db;
      logic               estimate_valid;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/m2m4_sqrt_cell.sv -----
`default_nettype none
module m2m4_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire logic        clock,
   input  wire logic [63:0] v_in,
   input  wire logic [63:0] r_in,
   output logic      [63:0] v_out,
   output logic      [63:0] r_out
);

   localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

   logic [64:0] trial;
   logic [63:0] v_ff, v_in_nxt;
   logic [63:0] r_ff, r_in_nxt;

   assign trial = {1'b0, r_in} + {1'b0, BIT};

   always_comb begin
      if ({1'b0, v_in} >= trial) begin
         v_in_nxt = v_in - trial[63:0];
         r_in_nxt = (r_in >> 1) + BIT;
      end else begin
         v_in_nxt = v_in;
         r_in_nxt = r_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in_nxt;
      r_ff <= r_in_nxt;
   end

   assign v_out = v_ff;
   assign r_out = r_ff;

endmodule
`default_nettype wire

// ----- rtl/m2m4_log_cell.sv -----
`default_nettype none
module m2m4_log_cell #(
   parameter int FRAC_BIT = 15
) (
   input  wire logic        clock,
   input  wire logic [31:0] m_in,
   input  wire logic [15:0] f_in,
   output logic      [31:0] m_out,
   output logic      [15:0] f_out
);

   logic [63:0] sq;
   logic [32:0] t;
   logic [31:0] m_ff, m_nxt;
   logic [15:0] f_ff, f_nxt;

   assign sq = 64'(m_in) * 64'(m_in);
   assign t  = sq[63:31];

   always_comb begin
      if (t[32]) begin
         m_nxt = t[32:1];
         f_nxt = f_in | (16'(1) << FRAC_BIT);
      end else begin
         m_nxt = t[31:0];
         f_nxt = f_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_nxt;
      f_ff <= f_nxt;
   end

   assign m_out = m_ff;
   assign f_out = f_ff;

endmodule
`default_nettype wire

// ----- rtl/mpsk_m2m4_snr_estimator_unit.sv -----
// M2M4 SNR estimator: takes one complex Q1.15 sample per beat, updates exponential
// averages of |x|^2 and |x|^4 weighted by alpha (Q0.16, csr write, reset 66), and
// returns signal power, noise power (Q2.30), SNR in Q8.8 dB and a valid flag. One
// sample is in flight at a time: the next sample is taken only once the previous result
// has left the pipeline and is not held in the pending register behind a stalled
// output. The pipeline holds the 32-cell square-root chain and two 16-cell log2
// chains. A finished result may wait on rsp_ready while the next sample is already
// being processed.
`default_nettype none
module mpsk_m2m4_snr_estimator_unit #(
   parameter int ALPHA_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire m2m4_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output m2m4_pkg::rsp_type          rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [ALPHA_BITS-1:0] csr_wdata
);

   localparam int SB = m2m4_pkg::SAMPLE_BITS;
   localparam int AW = ALPHA_BITS;
   localparam int AVW = m2m4_pkg::AVG_W;
   localparam int NR = m2m4_pkg::ROOT_STEPS;
   localparam int NL = m2m4_pkg::LOG_STEPS;
   localparam int PP_W = AW + 26;
   localparam int P_SHR = (2 * SB >= 32) ? 2 * SB - 32 : 0;
   localparam int P_SHL = (2 * SB >= 32) ? 0 : 32 - 2 * SB;
   localparam int T_SQ = 0;
   localparam int T_P = 1;
   localparam int T_BL2 = 2;
   localparam int T_BL4 = 3;
   localparam int T_M2 = 4;
   localparam int T_SQR = 5;
   localparam int T_RAD = 6;
   localparam int T_SIG = T_RAD + 1 + NR;
   localparam int T_NORM = T_SIG + 1;
   localparam int T_DIFF = T_NORM + 1 + NL;
   localparam int T_PROD = T_DIFF + 1;
   localparam int T_OUT = T_PROD + 1;
   localparam int TOK_LEN = T_OUT + 1;
   localparam logic [AW:0] ALPHA_ONE = {1'b1, {AW{1'b0}}};
   localparam logic [PP_W-1:0] HALF = PP_W'(1) << (AW - 1);

   function automatic logic [4:0] lead_one(input logic [31:0] x);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) e = 5'(i);
      end
      return e;
   endfunction

   function automatic logic [AVW-1:0] blend_sum(input logic [PP_W-1:0] hi,
                                               input logic [PP_W-1:0] lo);
      return AVW'((64'(hi) << (24 - AW)) + (64'(lo) >> AW));
   endfunction

   logic [AW-1:0] alpha_ff;
   logic [AW:0]   beta;
   logic [TOK_LEN-1:0] tok_ff, tok_in;
   logic accept, busy, done, rsp_free;

   logic signed [SB-1:0]   si_ff, sq_ff;
   logic signed [2*SB-1:0] si_sq, sq_sq;
   logic [2*SB-1:0]        sqi_ff, sqq_ff;
   logic [2*SB:0]          raw;
   logic [31:0]            p_ff;
   logic [63:0]            p_sq;
   logic [AVW-1:0]         x2, x4_ff;
   logic [PP_W-1:0]        hi2_ff, lo2_ff, hi4_ff, lo4_ff;
   logic [AVW-1:0]         m2_avg_ff, m4_avg_ff;
   logic [31:0]            m2_ff;
   logic [63:0]            m2_prod, m2sq2_ff, m4w_ff, rad_ff;
   logic                   neg_ff, ge_ff;
   logic [31:0]            sig_ff, noise_ff;
   logic [4:0]             es_ff, en_ff;
   logic [31:0]            ms_ff, mn_ff;
   logic signed [21:0]     d_ff;
   logic [20:0]            mag;
   logic                   dneg_ff;
   logic [46:0]            prod_ff;
   logic [47:0]            q_full;
   logic [15:0]            q;
   logic signed [16:0]     sn;
   logic signed [15:0]     snr_log;

   logic [63:0] sv [0:NR];
   logic [63:0] sr [0:NR];
   logic [31:0] lms [0:NL];
   logic [15:0] lfs [0:NL];
   logic [31:0] lmn [0:NL];
   logic [15:0] lfn [0:NL];

   m2m4_pkg::rsp_type res, rsp_ff, pend_ff;
   logic rsp_valid_ff, pend_valid_ff;

   assign csr_ready = 1'b1;
   assign beta = ALPHA_ONE - {1'b0, alpha_ff};
   assign busy = (|tok_ff) | pend_valid_ff;
   assign req_ready = !busy;
   assign accept = req_valid && req_ready;
   assign tok_in = {tok_ff[TOK_LEN-2:0], accept};
   assign done = tok_ff[T_OUT];
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= AW'(66);
      end else if (csr_valid) begin
         alpha_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign si_sq = si_ff * si_ff;
   assign sq_sq = sq_ff * sq_ff;
   assign raw = {1'b0, sqi_ff} + {1'b0, sqq_ff};
   assign p_sq = 64'(p_ff) * 64'(p_ff);
   assign x2 = {p_ff, 16'b0};
   assign m2_prod = 64'(m2_ff) * 64'(m2_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         si_ff <= req_data.sample_i;
         sq_ff <= req_data.sample_q;
      end
      if (tok_ff[T_SQ]) begin
         sqi_ff <= unsigned'(si_sq);
         sqq_ff <= unsigned'(sq_sq);
      end
      if (tok_ff[T_P]) begin
         p_ff <= 32'((64'(raw) >> P_SHR) << P_SHL);
      end
      if (tok_ff[T_BL2]) begin
         x4_ff  <= AVW'((p_sq + 64'd32768) >> 16);
         hi2_ff <= PP_W'(alpha_ff) * PP_W'(x2[47:24]) + PP_W'(beta) * PP_W'(m2_avg_ff[47:24]);
         lo2_ff <= PP_W'(alpha_ff) * PP_W'(x2[23:0]) + PP_W'(beta) * PP_W'(m2_avg_ff[23:0])
                   + HALF;
      end
      if (tok_ff[T_BL4]) begin
         hi4_ff <= PP_W'(alpha_ff) * PP_W'(x4_ff[47:24])
                   + PP_W'(beta) * PP_W'(m4_avg_ff[47:24]);
         lo4_ff <= PP_W'(alpha_ff) * PP_W'(x4_ff[23:0]) + PP_W'(beta) * PP_W'(m4_avg_ff[23:0])
                   + HALF;
      end
      if (tok_ff[T_M2]) begin
         m2_ff <= 32'((49'(m2_avg_ff) + 49'd32768) >> 16);
      end
      if (tok_ff[T_SQR]) begin
         m2sq2_ff <= m2_prod << 1;
         m4w_ff   <= {m4_avg_ff, 16'b0};
      end
      if (tok_ff[T_RAD]) begin
         neg_ff <= m2sq2_ff < m4w_ff;
         rad_ff <= m2sq2_ff - m4w_ff;
      end
      if (tok_ff[T_SIG]) begin
         sig_ff   <= sr[NR][31:0];
         ge_ff    <= sr[NR][31:0] >= m2_ff;
         noise_ff <= m2_ff - sr[NR][31:0];
      end
      if (tok_ff[T_NORM]) begin
         es_ff <= lead_one(sig_ff);
         en_ff <= lead_one(noise_ff);
         ms_ff <= sig_ff << (5'd31 - lead_one(sig_ff));
         mn_ff <= noise_ff << (5'd31 - lead_one(noise_ff));
      end
      if (tok_ff[T_DIFF]) begin
         d_ff <= signed'({1'b0, es_ff, lfs[NL]}) - signed'({1'b0, en_ff, lfn[NL]});
      end
      if (tok_ff[T_PROD]) begin
         dneg_ff <= d_ff < 0;
         prod_ff <= 47'(mag) * 47'(m2m4_pkg::DB_PER_LOG2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_avg_ff <= '0;
         m4_avg_ff <= '0;
      end else begin
         if (tok_ff[T_BL4]) m2_avg_ff <= blend_sum(hi2_ff, lo2_ff);
         if (tok_ff[T_M2])  m4_avg_ff <= blend_sum(hi4_ff, lo4_ff);
      end
   end

   assign sv[0] = rad_ff;
   assign sr[0] = '0;
   assign lms[0] = ms_ff;
   assign lfs[0] = '0;
   assign lmn[0] = mn_ff;
   assign lfn[0] = '0;

   for (genvar k = 0; k < NR; k++) begin : g_root
      m2m4_sqrt_cell #(.STEP(k)) u_cell (
         .clock(clock), .v_in(sv[k]), .r_in(sr[k]), .v_out(sv[k+1]), .r_out(sr[k+1])
      );
   end

   for (genvar j = 0; j < NL; j++) begin : g_log
      m2m4_log_cell #(.FRAC_BIT(NL - 1 - j)) u_sig (
         .clock(clock), .m_in(lms[j]), .f_in(lfs[j]), .m_out(lms[j+1]), .f_out(lfs[j+1])
      );
      m2m4_log_cell #(.FRAC_BIT(NL - 1 - j)) u_noise (
         .clock(clock), .m_in(lmn[j]), .f_in(lfn[j]), .m_out(lmn[j+1]), .f_out(lfn[j+1])
      );
   end

   assign mag = d_ff < 0 ? 21'(-d_ff) : 21'(d_ff);
   assign q_full = (48'(prod_ff) + 48'h8000_0000) >> 32;

   always_comb begin
      q = (q_full > 48'd32768) ? 16'h8000 : q_full[15:0];
      sn = dneg_ff ? -signed'({1'b0, q}) : signed'({1'b0, q});
      snr_log = (sn > 17'sd32767) ? 16'sd32767 : 16'(sn);
   end

   always_comb begin
      res = '0;
      priority if (neg_ff) begin
         res = '0;
      end else if (ge_ff) begin
         res.signal_power = sig_ff;
         res.snr_db = (sig_ff != 32'd0) ? 16'sd32767 : 16'sd0;
      end else begin
         res.signal_power = sig_ff;
         res.noise_power = noise_ff;
         res.estimate_valid = 1'b1;
         res.snr_db = (sig_ff == 32'd0) ? -16'sd32768 : snr_log;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         priority if (rsp_free && pend_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else if (rsp_free) begin
            rsp_valid_ff <= done;
         end else if (done) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (rsp_free && pend_valid_ff) begin
         rsp_ff <= pend_ff;
      end else if (rsp_free && done) begin
         rsp_ff <= res;
      end else if (done) begin
         pend_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/m2m4_checker.sv -----
`default_nettype none
module m2m4_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire m2m4_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken while one is in flight");

   a_valid_noise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.estimate_valid |-> rsp_data.noise_power != 32'd0)
      else $error("valid estimate with zero noise");

   a_invalid_noise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.estimate_valid |-> rsp_data.noise_power == 32'd0)
      else $error("invalid estimate with nonzero noise");

endmodule

bind mpsk_m2m4_snr_estimator_unit m2m4_checker u_m2m4_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

   localparam int ABITS = 16;
   localparam logic [63:0] MASK48 = (64'd1 << 48) - 1;
   localparam logic [63:0] MASK24 = (64'd1 << 24) - 1;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   m2m4_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   m2m4_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [ABITS-1:0] csr_wdata = '0;

   mpsk_m2m4_snr_estimator_unit #(.ALPHA_BITS(ABITS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   logic [63:0] alpha_q;
   logic [63:0] m2_avg;
   logic [63:0] m4_avg;
   m2m4_pkg::rsp_type estimate_q[$];
   int mismatches = 0;
   bit quiet = 0;
   bit hold_off = 0;

   initial forever #6 clock = ~clock;

   initial begin
      #(12 * 4000000);
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [63:0] blend(logic [63:0] x, logic [63:0] m, logic [63:0] a);
      logic [63:0] b, hi, lo;
      b = (64'd1 << ABITS) - a;
      hi = a * (x >> 24) + b * (m >> 24);
      lo = a * (x & MASK24) + b * (m & MASK24) + (64'd1 << (ABITS - 1));
      return ((hi << (24 - ABITS)) + (lo >> ABITS)) & MASK48;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint log2_fix(logic [31:0] x);
      int e;
      logic [63:0] m, f;
      e = 31;
      f = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      m = {32'd0, x} << (31 - e);
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            f |= 64'd1 << i;
            m >>= 1;
         end
      end
      return longint'((64'(e) << 16) | f);
   endfunction

   function automatic m2m4_pkg::rsp_type estimate_snr(m2m4_pkg::req_type s);
      longint si, sq, d, snr;
      logic [63:0] p, x4, m2, m2sq2, m4w, rad, sig, noise, mag, q;
      m2m4_pkg::rsp_type r;
      si = longint'(s.sample_i);
      sq = longint'(s.sample_q);
      p = 64'(si * si) + 64'(sq * sq);
      x4 = (p * p + (64'd1 << 15)) >> 16;
      m2_avg = blend(p << 16, m2_avg, alpha_q);
      m4_avg = blend(x4, m4_avg, alpha_q);
      m2 = (m2_avg + (64'd1 << 15)) >> 16;
      m2sq2 = 2 * (m2 * m2);
      m4w = m4_avg << 16;
      sig = 0;
      noise = 0;
      snr = 0;
      r = '0;
      if (m2sq2 >= m4w) begin
         rad = m2sq2 - m4w;
         sig = root_floor(rad) & 64'hFFFFFFFF;
         if (sig >= m2) begin
            snr = sig > 0 ? 32767 : 0;
         end else begin
            noise = m2 - sig;
            r.estimate_valid = 1;
            if (sig == 0) begin
               snr = -32768;
            end else begin
               d = log2_fix(sig[31:0]) - log2_fix(noise[31:0]);
               mag = 64'(d < 0 ? -d : d);
               q = (mag * 64'd50504453 + (64'd1 << 31)) >> 32;
               if (q > 32768) q = 32768;
               snr = d < 0 ? -longint'(q) : longint'(q);
               if (snr > 32767) snr = 32767;
            end
         end
      end
      r.signal_power = sig[31:0];
      r.noise_power = noise[31:0];
      r.snr_db = snr[15:0];
      return r;
   endfunction

   task automatic send_sample(logic [15:0] i, logic [15:0] q);
      m2m4_pkg::req_type s;
      s.sample_i = i;
      s.sample_q = q;
      @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(posedge clock);
      req_data <= s;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      estimate_q.push_back(estimate_snr(s));
      req_valid <= 0;
   endtask

   task automatic drain;
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_alpha(logic [ABITS-1:0] a);
      drain();
      csr_wdata <= a;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      alpha_q = 64'(a);
      csr_valid <= 0;
   endtask

   always @(posedge clock) begin
      if (!reset && !hold_off) begin
         if (quiet) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 5) != 0);
      end else if (hold_off) begin
         rsp_ready <= 0;
      end
   end

   always @(posedge clock) begin
      m2m4_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (estimate_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", rsp_data);
         end else begin
            e = estimate_q.pop_front();
            if (rsp_data.signal_power !== e.signal_power
                  || rsp_data.noise_power !== e.noise_power
                  || rsp_data.snr_db !== e.snr_db
                  || rsp_data.estimate_valid !== e.estimate_valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", e, rsp_data);
            end
         end
      end
   end

   task automatic test_directed;
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h7FFF);
      send_sample(16'hFFFF, 16'h0001);
      send_sample(16'h5555, 16'hAAAA);
      for (int k = 0; k < 8; k++) send_sample(16'h4000, 16'h0000);
      for (int k = 0; k < 6; k++) send_sample(k[0] ? 16'h7FFF : 16'h0000, 16'h0000);
   endtask

   task automatic test_alpha_extremes;
      write_alpha(16'hFFFF);
      send_sample(16'h7FFF, 16'h0000);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'h1234, 16'hEDCB);
      write_alpha(16'h0001);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'h0100, 16'h0000);
   endtask

   task automatic test_random(int n, bit noisy);
      logic [15:0] a, i, q;
      for (int k = 0; k < n; k++) begin
         if (noisy || $urandom_range(0, 4) == 0) begin
            i = 16'($urandom());
            q = 16'($urandom());
         end else begin
            a = 16'h4000 + 16'($urandom_range(0, 255));
            i = $urandom_range(0, 1) ? a : -a;
            q = $urandom_range(0, 1) ? a : -a;
         end
         send_sample(i, q);
      end
   endtask

   task automatic test_backpressure;
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         test_random(6, 0);
      join
   endtask

   initial begin
      alpha_q = 66;
      m2_avg = 0;
      m4_avg = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_alpha_extremes();
      write_alpha(16'd66);
      test_random(200, 0);
      test_backpressure();
      write_alpha(16'h8000);
      test_random(200, 1);
      write_alpha(16'($urandom_range(1, 65535)));
      test_random(250, 0);
      write_alpha(16'd4000);
      test_random(200, 0);
      quiet = 1;
      test_random(100, 0);
      drain();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
